// ===== design/kt_pkg.sv =====
// Shared token types, character classes and keyword table for the keyword tokenizer.
package kt_pkg;

  typedef enum logic [4:0] {
    K_ILLEGAL   = 5'd0,
    K_EOF       = 5'd1,
    K_IDENT     = 5'd2,
    K_INT       = 5'd3,
    K_ASSIGN    = 5'd4,
    K_PLUS      = 5'd5,
    K_MINUS     = 5'd6,
    K_BANG      = 5'd7,
    K_ASTERISK  = 5'd8,
    K_SLASH     = 5'd9,
    K_LT        = 5'd10,
    K_GT        = 5'd11,
    K_EQUAL     = 5'd12,
    K_NOT_EQUAL = 5'd13,
    K_COMMA     = 5'd14,
    K_SEMICOLON = 5'd15,
    K_LPAREN    = 5'd16,
    K_RPAREN    = 5'd17,
    K_LBRACE    = 5'd18,
    K_RBRACE    = 5'd19,
    K_LET       = 5'd20,
    K_FN        = 5'd21,
    K_TRUE      = 5'd22,
    K_FALSE     = 5'd23,
    K_IF        = 5'd24,
    K_ELSE      = 5'd25,
    K_RETURN    = 5'd26
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  localparam int MAX_TOKENS = 3;

  // tokens raised by one input item, packed from entry 0 upwards
  typedef struct packed {
    logic [1:0]   cnt;
    token_t [2:0] tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int NUM_KEYWORDS = 7;

  // keyword text, first character highest, right aligned
  localparam logic [63:0] KW_VAL [NUM_KEYWORDS] = '{
    64'h6C6574, 64'h666E, 64'h74727565, 64'h66616C7365,
    64'h6966, 64'h656C7365, 64'h72657475726E
  };
  localparam logic [15:0] KW_LEN [NUM_KEYWORDS] = '{
    16'd3, 16'd2, 16'd4, 16'd5, 16'd2, 16'd4, 16'd6
  };
  localparam token_kind_t KW_KIND [NUM_KEYWORDS] = '{
    K_LET, K_FN, K_TRUE, K_FALSE, K_IF, K_ELSE, K_RETURN
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic token_kind_t single_kind(input logic [7:0] c);
    token_kind_t k;
    unique case (c)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_ASTERISK;
      8'h2F:   k = K_SLASH;
      8'h3C:   k = K_LT;
      8'h3E:   k = K_GT;
      8'h2C:   k = K_COMMA;
      8'h3B:   k = K_SEMICOLON;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      default: k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  // exact match: length and every character must agree
  function automatic token_kind_t kw_kind(input logic [15:0] len, input logic [63:0] prefix);
    token_kind_t k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (len == KW_LEN[i] && prefix == KW_VAL[i]) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

// ===== design/kt_front.sv =====
// Front end: accepts source bytes, tracks runs and pending operators, builds token bundles.
module kt_front #(
  parameter int MAX_SOURCE_BYTES = 65536,
  parameter int KEYWORD_CHARS    = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_code,
  input  logic                 in_end_of_input,
  output logic                 push,
  output kt_pkg::bundle_t      push_data,
  input  kt_pkg::fifo_status_t fifo_st
);

  localparam int PW    = 8 * KEYWORD_CHARS;
  localparam int CAP_I = (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
  localparam logic [15:0] POS_CAP = 16'(CAP_I);

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_IDENT       = 3'd1,
    MODE_INT         = 3'd2,
    MODE_PEND_ASSIGN = 3'd3,
    MODE_PEND_BANG   = 3'd4
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [15:0]   rstart_r, rstart_nxt;
  logic [15:0]   rlen_r, rlen_nxt;
  logic [PW-1:0] prefix_r, prefix_nxt;

  logic          acc;
  logic          consumed;
  logic [15:0]   pos_bump;
  logic          fl_v, sg_v, ef_v;
  kt_pkg::token_t fl_tok, sg_tok, ef_tok, eof_tok;
  kt_pkg::bundle_t bnd;
  logic [1:0]    n;

  assign in_stall  = fifo_st.full;
  assign acc       = in_valid && !in_stall;
  assign push      = acc && (bnd.cnt != 2'd0);
  assign push_data = bnd;
  assign pos_bump  = (pos_r >= POS_CAP) ? POS_CAP : pos_r + 16'd1;

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    rstart_nxt = rstart_r;
    rlen_nxt   = rlen_r;
    prefix_nxt = prefix_r;
    consumed   = 1'b0;
    fl_v       = 1'b0;
    sg_v       = 1'b0;
    ef_v       = 1'b0;
    fl_tok     = '0;
    sg_tok     = '0;
    ef_tok     = '0;
    eof_tok    = '0;

    unique case (mode_r) inside
      MODE_IDENT: begin
        if (kt_pkg::is_letter(in_char_code)) begin
          consumed = 1'b1;
          if (rlen_r < 16'(KEYWORD_CHARS)) begin
            prefix_nxt = {prefix_r[PW-9:0], in_char_code};
          end
          if (rlen_r != 16'hFFFF) begin
            rlen_nxt = rlen_r + 16'd1;
          end
        end else begin
          fl_v     = 1'b1;
          fl_tok   = '{kt_pkg::kw_kind(rlen_r, 64'(prefix_r)), rstart_r, rlen_r};
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (kt_pkg::is_digit(in_char_code)) begin
          consumed = 1'b1;
          if (rlen_r != 16'hFFFF) begin
            rlen_nxt = rlen_r + 16'd1;
          end
        end else begin
          fl_v     = 1'b1;
          fl_tok   = '{kt_pkg::K_INT, rstart_r, rlen_r};
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_PEND_ASSIGN, MODE_PEND_BANG: begin
        fl_v     = 1'b1;
        mode_nxt = MODE_IDLE;
        if (in_char_code == 8'h3D) begin
          consumed = 1'b1;
          fl_tok   = '{(mode_r == MODE_PEND_ASSIGN) ? kt_pkg::K_EQUAL : kt_pkg::K_NOT_EQUAL,
                       rstart_r, 16'd2};
        end else begin
          fl_tok   = '{(mode_r == MODE_PEND_ASSIGN) ? kt_pkg::K_ASSIGN : kt_pkg::K_BANG,
                       rstart_r, 16'd1};
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase

    if (!consumed) begin
      if (kt_pkg::is_space(in_char_code)) begin
        mode_nxt = mode_nxt;
      end else if (kt_pkg::is_letter(in_char_code)) begin
        mode_nxt   = MODE_IDENT;
        rstart_nxt = pos_r;
        rlen_nxt   = 16'd1;
        prefix_nxt = PW'(in_char_code);
      end else if (kt_pkg::is_digit(in_char_code)) begin
        mode_nxt   = MODE_INT;
        rstart_nxt = pos_r;
        rlen_nxt   = 16'd1;
        prefix_nxt = '0;
      end else if (in_char_code == 8'h3D) begin
        mode_nxt   = MODE_PEND_ASSIGN;
        rstart_nxt = pos_r;
      end else if (in_char_code == 8'h21) begin
        mode_nxt   = MODE_PEND_BANG;
        rstart_nxt = pos_r;
      end else begin
        sg_v   = 1'b1;
        sg_tok = '{kt_pkg::single_kind(in_char_code), pos_r, 16'd1};
      end
    end

    if (in_end_of_input) begin
      // resolve whatever is still open, then close the text
      unique case (mode_nxt)
        MODE_IDENT: begin
          ef_v   = 1'b1;
          ef_tok = '{kt_pkg::kw_kind(rlen_nxt, 64'(prefix_nxt)), rstart_nxt, rlen_nxt};
        end
        MODE_INT: begin
          ef_v   = 1'b1;
          ef_tok = '{kt_pkg::K_INT, rstart_nxt, rlen_nxt};
        end
        MODE_PEND_ASSIGN: begin
          ef_v   = 1'b1;
          ef_tok = '{kt_pkg::K_ASSIGN, rstart_nxt, 16'd1};
        end
        MODE_PEND_BANG: begin
          ef_v   = 1'b1;
          ef_tok = '{kt_pkg::K_BANG, rstart_nxt, 16'd1};
        end
        default: ef_v = 1'b0;
      endcase
      eof_tok    = '{kt_pkg::K_EOF, pos_bump, 16'd0};
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      rstart_nxt = '0;
      rlen_nxt   = '0;
      prefix_nxt = '0;
    end else begin
      pos_nxt = pos_bump;
    end
  end

  // pack the tokens in emission order
  always_comb begin
    bnd = '0;
    n   = 2'd0;
    if (fl_v) begin
      bnd.tok[n] = fl_tok;
      n          = n + 2'd1;
    end
    if (sg_v) begin
      bnd.tok[n] = sg_tok;
      n          = n + 2'd1;
    end
    if (ef_v) begin
      bnd.tok[n] = ef_tok;
      n          = n + 2'd1;
    end
    if (in_end_of_input) begin
      bnd.tok[n] = eof_tok;
      n          = n + 2'd1;
    end
    bnd.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      rstart_r <= '0;
      rlen_r   <= '0;
      prefix_r <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      rstart_r <= rstart_nxt;
      rlen_r   <= rlen_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

// ===== design/kt_fifo.sv =====
// Short bundle queue between the front end and the token sequencer.
module kt_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  kt_pkg::bundle_t      wr_data,
  input  logic                 rd_en,
  output kt_pkg::bundle_t      rd_data,
  output kt_pkg::fifo_status_t st
);

  kt_pkg::bundle_t                mem [kt_pkg::FIFO_DEPTH];
  logic [kt_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [kt_pkg::FIFO_CW-1:0]     count_r;

  assign st.full  = (count_r == kt_pkg::FIFO_CW'(kt_pkg::FIFO_DEPTH));
  assign st.empty = (count_r == '0);
  assign rd_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + kt_pkg::FIFO_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + kt_pkg::FIFO_AW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + kt_pkg::FIFO_CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - kt_pkg::FIFO_CW'(1);
      end
    end
  end

endmodule

// ===== design/kt_back.sv =====
// Back end: takes bundles from the queue and issues their tokens one per cycle while out_stall is low.
module kt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 pop,
  input  kt_pkg::bundle_t      pop_data,
  input  kt_pkg::fifo_status_t fifo_st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4:0]           out_token_kind,
  output logic [15:0]          out_token_start,
  output logic [15:0]          out_token_length,
  output logic                 out_last_of_run
);

  kt_pkg::bundle_t cur_r;
  logic [1:0]      idx_r;
  logic            have_r;
  logic            out_acc, last_tok, need;
  kt_pkg::token_t  tok;

  assign tok      = cur_r.tok[idx_r];
  assign last_tok = (idx_r == cur_r.cnt - 2'd1);
  assign out_acc  = have_r && !out_stall;
  assign need     = !have_r || (out_acc && last_tok);
  assign pop      = need && !fifo_st.empty;

  assign out_valid        = have_r;
  assign out_token_kind   = tok.kind;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.length;
  assign out_last_of_run  = last_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= '0;
    end else if (need) begin
      have_r <= pop;
      idx_r  <= '0;
    end else if (out_acc) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_data;
    end
  end

endmodule

// ===== design/keyword_tokenizer.sv =====
// Streaming lexer top level: front end, bundle queue and token sequencer.
// With the queue and output idle, the first token of a byte is written to the bundle queue,
// then popped into the back-end output register and presented from there.
// Throughput: one byte per cycle in while the queue is not full; one token per cycle out
// while out_stall is low, and the 4-entry queue absorbs bursts of bytes that raise several tokens.
// Reset: synchronous, active low; clears scan state, offsets, queue and output stage.
module keyword_tokenizer #(
  parameter int MAX_SOURCE_BYTES = 65536,
  parameter int KEYWORD_CHARS    = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  logic                 push, pop;
  kt_pkg::bundle_t      push_data, pop_data;
  kt_pkg::fifo_status_t fifo_st;

  kt_front #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
    .KEYWORD_CHARS   (KEYWORD_CHARS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_input(in_end_of_input),
    .push           (push),
    .push_data      (push_data),
    .fifo_st        (fifo_st)
  );

  kt_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(push_data),
    .rd_en  (pop),
    .rd_data(pop_data),
    .st     (fifo_st)
  );

  kt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop             (pop),
    .pop_data        (pop_data),
    .fifo_st         (fifo_st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_token_start (out_token_start),
    .out_token_length(out_token_length),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== design/kt_checker.sv =====
// Port-level checks for the keyword tokenizer, bound to the top level.
module kt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic        out_last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
      $stable(out_token_start) && $stable(out_token_length) && $stable(out_last_of_run))
    else $error("stalled output item changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == kt_pkg::K_EOF |-> out_last_of_run && out_token_length == 16'd0)
    else $error("eof token malformed");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == kt_pkg::K_EQUAL || out_token_kind == kt_pkg::K_NOT_EQUAL)
      |-> out_token_length == 16'd2)
    else $error("two-character operator with wrong length");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= kt_pkg::K_RETURN)
    else $error("token kind out of range");

endmodule

bind keyword_tokenizer kt_checker u_kt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_token_kind  (out_token_kind),
  .out_token_start (out_token_start),
  .out_token_length(out_token_length),
  .out_last_of_run (out_last_of_run)
);

// ===== sim/tb.sv =====
// Testbench for keyword_tokenizer: byte stream in, predicted tokens checked in order.
`timescale 1ns / 100ps

module tb;

  localparam int PREFIX_CHARS   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 290;

  typedef enum logic [2:0] {
    SCAN_IDLE  = 3'd0,
    SCAN_IDENT = 3'd1,
    SCAN_INT   = 3'd2,
    SCAN_EQ    = 3'd3,
    SCAN_BANG  = 3'd4
  } scan_t;

  typedef struct packed {
    logic [7:0] code;
    logic       eoi;
    logic       hold;
  } src_byte_t;

  typedef struct packed {
    kt_pkg::token_kind_t kind;
    logic [15:0]         start;
    logic [15:0]         len;
    logic                last;
  } tok_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  src_byte_t src_q[$];
  tok_rec_t  token_q[$];
  logic      next_hold = 1'b0;
  int        errors = 0;
  int        idle_cycles = 0;
  int        gap_left = 0;
  int        burst_left = 1;
  int        drained_for = 0;
  int        stall_style = 0;
  int        phase_left = 0;
  logic [7:0] stall_pat = 8'h00;
  int        rand_start;
  int        n_texts;
  string     kw_list[7] = '{"let", "fn", "true", "false", "if", "else", "return"};
  string     op_chars = "+-*/<>,;(){}=!";

  // lexer state as the block should hold it
  scan_t                     lx_mode = SCAN_IDLE;
  logic [15:0]               lx_pos = '0;
  logic [15:0]               lx_start = '0;
  logic [15:0]               lx_len = '0;
  logic [8*PREFIX_CHARS-1:0] lx_prefix = '0;
  tok_rec_t                  step_buf[3];
  int                        step_n;

  keyword_tokenizer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic char_is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic char_is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_is_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic [15:0] next_pos(input logic [15:0] p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  function automatic kt_pkg::token_kind_t op_kind(input logic [7:0] c);
    case (c)
      "+":     return kt_pkg::K_PLUS;
      "-":     return kt_pkg::K_MINUS;
      "*":     return kt_pkg::K_ASTERISK;
      "/":     return kt_pkg::K_SLASH;
      "<":     return kt_pkg::K_LT;
      ">":     return kt_pkg::K_GT;
      ",":     return kt_pkg::K_COMMA;
      ";":     return kt_pkg::K_SEMICOLON;
      "(":     return kt_pkg::K_LPAREN;
      ")":     return kt_pkg::K_RPAREN;
      "{":     return kt_pkg::K_LBRACE;
      "}":     return kt_pkg::K_RBRACE;
      default: return kt_pkg::K_ILLEGAL;
    endcase
  endfunction

  // exact keyword match only
  function automatic kt_pkg::token_kind_t word_kind(input logic [15:0] len,
                                                    input logic [8*PREFIX_CHARS-1:0] pfx);
    if (len == 16'd3 && pfx == "let") return kt_pkg::K_LET;
    if (len == 16'd2 && pfx == "fn") return kt_pkg::K_FN;
    if (len == 16'd4 && pfx == "true") return kt_pkg::K_TRUE;
    if (len == 16'd5 && pfx == "false") return kt_pkg::K_FALSE;
    if (len == 16'd2 && pfx == "if") return kt_pkg::K_IF;
    if (len == 16'd4 && pfx == "else") return kt_pkg::K_ELSE;
    if (len == 16'd6 && pfx == "return") return kt_pkg::K_RETURN;
    return kt_pkg::K_IDENT;
  endfunction

  task automatic add_tok(input kt_pkg::token_kind_t k, input logic [15:0] s,
                         input logic [15:0] n);
    if (step_n < 3) begin
      step_buf[step_n] = '{kind: k, start: s, len: n, last: 1'b0};
      step_n++;
    end
  endtask

  task automatic grow_run(input logic [7:0] c, input logic letter);
    if (letter && lx_len < PREFIX_CHARS) lx_prefix = (lx_prefix << 8) | c;
    if (lx_len != 16'hFFFF) lx_len++;
  endtask

  task automatic close_run();
    case (lx_mode)
      SCAN_IDENT: add_tok(word_kind(lx_len, lx_prefix), lx_start, lx_len);
      SCAN_INT:   add_tok(kt_pkg::K_INT, lx_start, lx_len);
      SCAN_EQ:    add_tok(kt_pkg::K_ASSIGN, lx_start, 16'd1);
      SCAN_BANG:  add_tok(kt_pkg::K_BANG, lx_start, 16'd1);
      default:    ;
    endcase
    lx_mode = SCAN_IDLE;
  endtask

  // tokens that one accepted byte should raise, queued in order
  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    logic [15:0] here;
    logic        taken;
    here   = lx_pos;
    taken  = 1'b0;
    step_n = 0;
    case (lx_mode) inside
      SCAN_IDENT: begin
        if (char_is_letter(c)) begin
          grow_run(c, 1'b1);
          taken = 1'b1;
        end else close_run();
      end
      SCAN_INT: begin
        if (char_is_digit(c)) begin
          grow_run(c, 1'b0);
          taken = 1'b1;
        end else close_run();
      end
      SCAN_EQ, SCAN_BANG: begin
        if (c == "=") begin
          add_tok(lx_mode == SCAN_EQ ? kt_pkg::K_EQUAL : kt_pkg::K_NOT_EQUAL,
                  lx_start, 16'd2);
          lx_mode = SCAN_IDLE;
          taken = 1'b1;
        end else close_run();
      end
      default: lx_mode = SCAN_IDLE;
    endcase
    if (!taken) begin
      if (char_is_space(c)) begin
      end else if (char_is_letter(c)) begin
        lx_mode   = SCAN_IDENT;
        lx_start  = here;
        lx_len    = '0;
        lx_prefix = '0;
        grow_run(c, 1'b1);
      end else if (char_is_digit(c)) begin
        lx_mode   = SCAN_INT;
        lx_start  = here;
        lx_len    = 16'd1;
        lx_prefix = '0;
      end else if (c == "=") begin
        lx_mode  = SCAN_EQ;
        lx_start = here;
      end else if (c == "!") begin
        lx_mode  = SCAN_BANG;
        lx_start = here;
      end else add_tok(op_kind(c), here, 16'd1);
    end
    if (eoi) begin
      close_run();
      add_tok(kt_pkg::K_EOF, next_pos(here), 16'd0);
      lx_mode   = SCAN_IDLE;
      lx_pos    = '0;
      lx_start  = '0;
      lx_len    = '0;
      lx_prefix = '0;
    end else lx_pos = next_pos(here);
    for (int i = 0; i < step_n; i++) begin
      step_buf[i].last = (i == step_n - 1);
      token_q.push_back(step_buf[i]);
    end
  endtask

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // stimulus helpers
  task automatic push_byte(input logic [7:0] c, input logic eoi);
    src_q.push_back('{code: c, eoi: eoi, hold: next_hold});
    next_hold = 1'b0;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 3))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0D;
      default: return " ";
    endcase
  endfunction

  function automatic logic [7:0] end_char();
    case ($urandom_range(0, 6))
      0:       return rand_letter();
      1:       return 8'("0" + $urandom_range(0, 9));
      2:       return "=";
      3:       return "!";
      4:       return ";";
      5:       return space_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_token();
    string w;
    int    k;
    int    n;
    case ($urandom_range(0, 9)) inside
      0, 1: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        repeat (n) push_byte(rand_letter(), 1'b0);
      end
      2, 3: begin
        // keyword, or a near miss: one letter too many or too few
        w = kw_list[$urandom_range(0, 6)];
        k = $urandom_range(0, 3);
        n = (k == 3) ? w.len() - 1 : w.len();
        for (int i = 0; i < n; i++) push_byte(w[i], 1'b0);
        if (k == 2) push_byte(rand_letter(), 1'b0);
      end
      4: begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
      5, 6, 7: begin
        k = $urandom_range(0, op_chars.len() - 1);
        push_byte(op_chars[k], 1'b0);
        if ((op_chars[k] == "=" || op_chars[k] == "!") && $urandom_range(0, 1))
          push_byte("=", 1'b0);
      end
      8: begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(space_char(), 1'b0);
      end
      default: push_byte(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  task automatic random_text(input logic hold);
    int n_tok;
    next_hold = hold;
    n_tok = $urandom_range(1, 10);
    repeat (n_tok) begin
      random_token();
      if ($urandom_range(0, 1)) push_byte(space_char(), 1'b0);
    end
    push_byte(end_char(), 1'b1);
  endtask

  // sender: bursts and gaps, holds a stalled item, waits for drain on marked items
  always @(posedge clk) begin
    src_byte_t nb;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_char_code    <= 8'h00;
      in_end_of_input <= 1'b0;
    end else begin
      drained_for = (token_q.size() == 0) ? drained_for + 1 : 0;
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (src_q.size() != 0 && (!src_q[0].hold || drained_for >= 4)) begin
          nb = src_q.pop_front();
          in_valid        <= 1'b1;
          in_char_code    <= nb.code;
          in_end_of_input <= nb.eoi;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else burst_left--;
        end else in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: changes style every so often
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        stall_style = $urandom_range(0, 3);
        phase_left  = $urandom_range(20, 120);
        stall_pat   = 8'($urandom);
      end else phase_left--;
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= stall_pat[0];
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // predict on accepted bytes, check accepted tokens, watchdog
  always @(posedge clk) begin
    tok_rec_t want;
    logic     took_in;
    logic     took_out;
    if (rst_n) begin
      took_in  = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (took_in) lex_byte(in_char_code, in_end_of_input);
      if (took_out) begin
        if (token_q.size() == 0) begin
          $display("%0t: token expected none actual kind %0d start %0d length %0d", $time,
                   out_token_kind, out_token_start, out_token_length);
          errors++;
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", 16'(want.kind), 16'(out_token_kind));
          check_field("token_start", want.start, out_token_start);
          check_field("token_length", want.len, out_token_length);
          check_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
        end
      end
      idle_cycles = (took_in || took_out) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("keyword_tokenizer test failed");
        $finish;
      end
    end
  end

  initial begin
    // ==, != and a pending = resolved at end; zero and non-ASCII bytes
    push_str("return!=9==");
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte("=", 1'b1);
    // pending ! resolved at end
    push_byte(8'h09, 1'b0);
    push_byte("!", 1'b1);
    // end flag on the first byte of a text
    push_byte("}", 1'b1);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h0D, 1'b0);
    push_byte(" ", 1'b0);
    push_byte("_", 1'b1);
    // keyword prefix on an overlong run
    push_str("return");
    repeat (3) push_byte(rand_letter(), 1'b0);
    push_byte(";", 1'b0);
    push_byte("7", 1'b1);

    rand_start = src_q.size();
    n_texts = 0;
    while (src_q.size() - rand_start < RANDOM_BYTES) begin
      random_text(n_texts == 1 || $urandom_range(0, 5) == 0);
      n_texts++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (src_q.size() != 0 || in_valid) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("keyword_tokenizer test passed");
    end else begin
      $display("keyword_tokenizer test failed");
    end
    $finish;
  end

endmodule
